// ===== design/ghtbl_pkg.sv =====
// Package: slot table geometry, operation codes, slot word and control types.
`default_nettype none

package ghtbl_pkg;

	localparam int ChunkSize  = 64;
	localparam int ChunkCount = 16;
	localparam int SlotTotal  = ChunkSize * ChunkCount;
	localparam int SlotAw     = (SlotTotal > 1) ? $clog2(SlotTotal) : 1;

	typedef enum logic [2:0] {
		OP_PUBLISH   = 3'd0,
		OP_RETIRE    = 3'd1,
		OP_PIN       = 3'd2,
		OP_UNPIN     = 3'd3,
		OP_COUNT_IDX = 3'd4,
		OP_COUNT_HND = 3'd5,
		OP_CLEAR_IDX = 3'd6,
		OP_CLEAR_HND = 3'd7
	} op_t;

	// One table entry as held in the slot RAM
	typedef struct packed {
		logic [31:0] gen;
		logic        live;
		logic [63:0] ptr;
		logic        present;
		logic [31:0] count;
	} slot_t;

	typedef struct packed {
		logic              ready;
		logic              commit;
		logic              wipe;
		logic [SlotAw-1:0] wipe_addr;
	} ghtbl_cmd_t;

	typedef struct packed {
		logic req_valid;
		logic out_busy;
	} ghtbl_sts_t;

endpackage

`default_nettype wire

// ===== design/ghtbl_req_if.sv =====
// Interface: request channel (operation and handle or slot fields).
`default_nettype none

interface ghtbl_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [31:0] slot_index;
	logic [31:0] generation;
	logic [63:0] pointer_value;

	modport source (output valid, operation, slot_index, generation, pointer_value,
		input ready);
	modport sink (input valid, operation, slot_index, generation, pointer_value,
		output ready);
endinterface

`default_nettype wire

// ===== design/ghtbl_rsp_if.sv =====
// Interface: response channel (success, pointer and pin count).
`default_nettype none

interface ghtbl_rsp_if;
	logic        valid;
	logic        ready;
	logic        success;
	logic [63:0] pointer_out;
	logic [30:0] pin_total;

	modport source (output valid, success, pointer_out, pin_total, input ready);
	modport sink (input valid, success, pointer_out, pin_total, output ready);
endinterface

`default_nettype wire

// ===== design/ghtbl_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module ghtbl_ram #(
	parameter int Width = 8,
	parameter int Depth = 16,
	localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [Aw-1:0]    wr_addr,
	input  wire logic [Width-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [Aw-1:0]    rd_addr,
	output logic      [Width-1:0] rd_data
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== design/ghtbl_ctrl.sv =====
// Controller: clearing sweep after reset, accept and execute sequencing.
`default_nettype none

module ghtbl_ctrl
	import ghtbl_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire ghtbl_sts_t sts,
	output ghtbl_cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	localparam logic [SlotAw-1:0] LastSlot = SlotAw'(SlotTotal - 1);

	state_t            state_q;
	logic [SlotAw-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + SlotAw'(1);
					if (clr_q == LastSlot) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (sts.req_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (!sts.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	always_comb begin
		cmd.ready     = (state_q == ST_IDLE);
		cmd.commit    = (state_q == ST_EXEC) && !sts.out_busy;
		cmd.wipe      = (state_q == ST_CLEAR);
		cmd.wipe_addr = clr_q;
	end

endmodule

`default_nettype wire

// ===== design/ghtbl_dp.sv =====
// Datapath: request capture, slot RAM, slot update and response register.
`default_nettype none

module ghtbl_dp
	import ghtbl_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire ghtbl_cmd_t cmd,
	output ghtbl_sts_t      sts,
	ghtbl_req_if.sink       req,
	ghtbl_rsp_if.source     rsp
);

	logic        accept;
	logic [2:0]  op_q;
	logic [31:0] idx_q;
	logic [31:0] gen_q;
	logic [63:0] ptr_q;

	slot_t       cur;
	slot_t       nxt;
	logic        we;
	logic        ok;
	logic [63:0] pout;
	logic [30:0] total;
	logic        in_range;
	logic        handle_zero;

	logic              ram_we;
	logic [SlotAw-1:0] ram_waddr;
	slot_t             ram_wdata;

	logic        out_valid_q;
	logic        success_q;
	logic [63:0] pointer_q;
	logic [30:0] total_q;

	assign req.ready = cmd.ready;
	assign accept    = req.valid && cmd.ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.operation;
			idx_q <= req.slot_index;
			gen_q <= req.generation;
			ptr_q <= req.pointer_value;
		end
	end

	// Sweep writes zero; otherwise write back the updated slot
	assign ram_we    = cmd.wipe || (cmd.commit && we);
	assign ram_waddr = cmd.wipe ? cmd.wipe_addr : idx_q[SlotAw-1:0];
	assign ram_wdata = cmd.wipe ? slot_t'('0) : nxt;

	ghtbl_ram #(
		.Width($bits(slot_t)),
		.Depth(SlotTotal)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(ram_wdata),
		.rd_en  (accept),
		.rd_addr(req.slot_index[SlotAw-1:0]),
		.rd_data(cur)
	);

	assign in_range    = (idx_q < 32'(SlotTotal));
	assign handle_zero = (idx_q == '0) && (gen_q == '0);

	always_comb begin
		nxt   = cur;
		we    = 1'b0;
		ok    = 1'b0;
		pout  = '0;
		total = '0;
		case (op_t'(op_q))
			OP_PUBLISH: begin
				if (gen_q != '0 && in_range) begin
					nxt.present = 1'b1;
					nxt.ptr     = ptr_q;
					nxt.gen     = gen_q;
					nxt.live    = 1'b1;
					we          = 1'b1;
					ok          = 1'b1;
				end
			end
			OP_RETIRE: begin
				if (in_range) begin
					nxt.live = 1'b0;
					we       = 1'b1;
				end
			end
			OP_PIN: begin
				if (!handle_zero && in_range && cur.live && cur.gen == gen_q
					&& cur.present) begin
					nxt.count = cur.count + 32'd1;
					we        = 1'b1;
					ok        = 1'b1;
					pout      = cur.ptr;
				end
			end
			OP_UNPIN: begin
				if (!handle_zero && in_range && cur.present) begin
					nxt.count = cur.count - 32'd1;
					we        = 1'b1;
				end
			end
			OP_COUNT_IDX, OP_COUNT_HND: begin
				// negative counts read as zero
				if (!(op_t'(op_q) == OP_COUNT_HND && handle_zero) && in_range
					&& cur.present && !cur.count[31]) begin
					total = cur.count[30:0];
				end
			end
			OP_CLEAR_IDX, OP_CLEAR_HND: begin
				if (!(op_t'(op_q) == OP_CLEAR_HND && handle_zero) && in_range
					&& cur.present) begin
					nxt.count = '0;
					we        = 1'b1;
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			success_q <= ok;
			pointer_q <= pout;
			total_q   <= total;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.success     = success_q;
	assign rsp.pointer_out = pointer_q;
	assign rsp.pin_total   = total_q;

	assign sts.req_valid = req.valid;
	assign sts.out_busy  = out_valid_q && !rsp.ready;

endmodule

`default_nettype wire

// ===== design/generation_checked_handle_table_top.sv =====
// Top level: generation-checked handle table with per-slot pin counters.
//
//  channel | dir | payload                                          | transaction
//  --------+-----+--------------------------------------------------+------------------
//  req     | in  | operation, slot_index, generation, pointer_value | valid & ready
//  rsp     | out | success, pointer_out, pin_total                  | valid & ready
//
// Each request is one read-modify-write of a slot held in a single RAM: read
// in the accept cycle at the registered read port, update and write-back in
// the execute step, which holds while an earlier result is still not taken.
// After reset a clearing sweep zeroes all 1024 slots, one per cycle, with
// req.ready held low until the sweep ends.
// The response register frees the request side: a new request is taken while
// a result still waits; its execute step holds until that result is taken.
`default_nettype none

module generation_checked_handle_table_top
	import ghtbl_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	ghtbl_req_if.sink   req,
	ghtbl_rsp_if.source rsp
);

	ghtbl_cmd_t cmd;
	ghtbl_sts_t sts;

	// sequencing: sweep, accept, execute
	ghtbl_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.sts   (sts),
		.cmd   (cmd)
	);

	// slot storage, update logic and response register
	ghtbl_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.sts   (sts),
		.req   (req),
		.rsp   (rsp)
	);

endmodule

`default_nettype wire

// ===== design/ghtbl_chk.sv =====
// Checker: port-level properties of the handle table, bound to the top level.
`default_nettype none

module ghtbl_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic        success,
	input wire logic [63:0] pointer_out,
	input wire logic [30:0] pin_total
);

	// one request in flight: ready drops right after a transaction
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted on consecutive cycles");

	// successful publish or pin never carries a count
	a_success_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && success |-> pin_total == '0)
		else $error("pin_total nonzero on a successful response");

	// a pointer is only returned by a granted pin
	a_pointer_needs_success: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && pointer_out != '0 |-> success)
		else $error("pointer returned without success");

	// response held until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped before transaction");

endmodule

bind generation_checked_handle_table_top ghtbl_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.success    (rsp.success),
	.pointer_out(rsp.pointer_out),
	.pin_total  (rsp.pin_total)
);

`default_nettype wire
